>>> rtl/core/dense_matrix_vector_multiply_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dense matrix-vector multiply core
// Shared helpers for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef DENSE_MATRIX_VECTOR_MULTIPLY_CORE_DEFINES_SVH
`define DENSE_MATRIX_VECTOR_MULTIPLY_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DMV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/dmv_pkg.sv
// ----------------------------------------------------------------------------
// dmv_pkg
// Types and fixed constants shared by the matrix-vector multiply core.
// ----------------------------------------------------------------------------
package dmv_pkg;

    localparam int VALUE_W     = 32;
    localparam int VEC_IDX_W   = 8;
    localparam int ROW_IDX_W   = 12;
    localparam int NUM_COLS_W  = 9;
    localparam int NUM_ROWS_W  = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_MATRIX = 1'b1;

    // Control that travels alongside one matrix element through the pipeline.
    typedef struct packed {
        logic                 valid;
        logic                 row_end;
        logic                 last_row;
        logic [ROW_IDX_W-1:0] row_index;
    } dmv_ctl_t;

endpackage

>>> rtl/core/dense_matrix_vector_multiply_core.sv
// ----------------------------------------------------------------------------
// dense_matrix_vector_multiply_core
// Streamed signed 32-bit matrix-vector product with a vector store.
// ----------------------------------------------------------------------------
// One input transfer is taken per clock while s_axis_tready is high. A load
// transfer (tuser 0) writes the vector store; a matrix transfer (tuser 1)
// reads the store entry for its column when taken, is then multiplied and
// accumulated, and each row sum is then held in the output register.
// Input is held off only when a finished row sum finds the previous one
// still waiting on the output. Set num_cols and num_rows while no rows are
// in flight; every vector entry a row uses must be loaded before that row
// streams in. The store needs no clearing pass.
module dense_matrix_vector_multiply_core #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] vec_index, [39:8] value
    input  logic [dmv_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] opcode
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] row_sum, [43:32] row_index, [47:44] zero
    output logic [dmv_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               cfg_we,
    input  logic [dmv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dmv_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    logic [CW:0]                     cols_lim_reg;
    logic [RW:0]                     rows_lim_reg;
    logic [CW-1:0]                   col_reg;
    logic [CW-1:0]                   col_next;
    logic [RW-1:0]                   row_reg;
    logic [RW-1:0]                   row_next;
    logic [dmv_pkg::NUM_COLS_W-1:0]  cfg_cols;
    logic [dmv_pkg::NUM_ROWS_W-1:0]  cfg_rows;
    logic [CW:0]                     cols_clamped;
    logic [RW:0]                     rows_clamped;
    logic [dmv_pkg::VEC_IDX_W-1:0]   vec_index;
    logic [dmv_pkg::VALUE_W-1:0]     value;
    logic                            accept;
    logic                            mat_accept;
    logic                            load_accept;
    logic                            row_end;
    logic                            last_row;
    logic [31:0]                     row_wide;
    logic                            advance;
    logic [dmv_pkg::VALUE_W-1:0]     vec_data;
    logic [dmv_pkg::VALUE_W-1:0]     row_sum;
    logic [dmv_pkg::ROW_IDX_W-1:0]   row_index;
    dmv_pkg::dmv_ctl_t               ctl;

    assign vec_index = s_axis_tdata[dmv_pkg::VEC_IDX_W-1:0];
    assign value     = s_axis_tdata[dmv_pkg::VEC_IDX_W +: dmv_pkg::VALUE_W];

    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mat_accept    = accept && (s_axis_tuser == dmv_pkg::OP_MATRIX);
    // Indexes beyond the store are dropped.
    assign load_accept   = accept && (s_axis_tuser == dmv_pkg::OP_LOAD)
                           && (32'(vec_index) < MAX_COLS);

    // Sizes are clamped once, when written.
    assign cfg_cols = cfg_data[dmv_pkg::NUM_COLS_W-1:0];
    assign cfg_rows = cfg_data[dmv_pkg::NUM_ROWS_W-1:0];

    always_comb
    begin
        if (cfg_cols == '0)
            cols_clamped = (CW+1)'(1);
        else if (32'(cfg_cols) > MAX_COLS)
            cols_clamped = (CW+1)'(MAX_COLS);
        else
            cols_clamped = (CW+1)'(cfg_cols);

        if (cfg_rows == '0)
            rows_clamped = (RW+1)'(1);
        else if (32'(cfg_rows) > MAX_ROWS)
            rows_clamped = (RW+1)'(MAX_ROWS);
        else
            rows_clamped = (RW+1)'(cfg_rows);
    end

    assign row_end  = ({1'b0, col_reg} + (CW+1)'(1)) >= cols_lim_reg;
    assign last_row = ({1'b0, row_reg} + (RW+1)'(1)) >= rows_lim_reg;
    assign row_wide = 32'(row_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (mat_accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_lim_reg <= (CW+1)'(1);
            rows_lim_reg <= (RW+1)'(1);
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    dmv_pkg::REG_NUM_COLS: cols_lim_reg <= cols_clamped;
                    dmv_pkg::REG_NUM_ROWS: rows_lim_reg <= rows_clamped;
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        ctl.valid     = mat_accept;
        ctl.row_end   = row_end;
        ctl.last_row  = last_row;
        ctl.row_index = row_wide[dmv_pkg::ROW_IDX_W-1:0];
    end

    dmv_vec_mem #(
        .DEPTH (MAX_COLS),
        .AW    (CW)
    ) u_vec_mem (
        .clk     (clk),
        .wr_en   (load_accept),
        .wr_addr (CW'(vec_index)),
        .wr_data (value),
        .rd_en   (mat_accept),
        .rd_addr (col_reg),
        .rd_data (vec_data)
    );

    dmv_mac u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl_in        (ctl),
        .value_in      (value),
        .vec_data      (vec_data),
        .advance       (advance),
        .res_valid     (m_axis_tvalid),
        .res_ready     (m_axis_tready),
        .res_sum       (row_sum),
        .res_row_index (row_index),
        .res_last_row  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, row_index, row_sum};

endmodule

>>> rtl/core/dmv_vec_mem.sv
// ----------------------------------------------------------------------------
// dmv_vec_mem
// Vector element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dmv_vec_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [dmv_pkg::VALUE_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [dmv_pkg::VALUE_W-1:0]  rd_data
);

    logic [dmv_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [dmv_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/dmv_mac.sv
// ----------------------------------------------------------------------------
// dmv_mac
// Multiply stage, accumulate stage and result register.
// ----------------------------------------------------------------------------
module dmv_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dmv_pkg::dmv_ctl_t                 ctl_in,
    input  logic [dmv_pkg::VALUE_W-1:0]       value_in,
    input  logic [dmv_pkg::VALUE_W-1:0]       vec_data,
    output logic                              advance,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [dmv_pkg::VALUE_W-1:0]       res_sum,
    output logic [dmv_pkg::ROW_IDX_W-1:0]     res_row_index,
    output logic                              res_last_row
);

    dmv_pkg::dmv_ctl_t             ctl1_reg;
    dmv_pkg::dmv_ctl_t             ctl2_reg;
    logic [dmv_pkg::VALUE_W-1:0]   value1_reg;
    logic [dmv_pkg::VALUE_W-1:0]   prod2_reg;
    logic [dmv_pkg::VALUE_W-1:0]   sum_reg;
    logic [dmv_pkg::VALUE_W-1:0]   sum_next;
    logic [dmv_pkg::VALUE_W-1:0]   acc;
    logic [dmv_pkg::VALUE_W-1:0]   prod;
    logic                          out_valid_reg;
    logic [dmv_pkg::VALUE_W-1:0]   out_sum_reg;
    logic [dmv_pkg::ROW_IDX_W-1:0] out_idx_reg;
    logic                          out_last_reg;
    logic                          emit;

    // The pipe only halts when a finished row meets a result still waiting.
    assign advance = !(ctl2_reg.valid && ctl2_reg.row_end && out_valid_reg && !res_ready);
    assign emit    = advance && ctl2_reg.valid && ctl2_reg.row_end;

    assign prod = dmv_pkg::VALUE_W'(value1_reg * vec_data);
    assign acc  = sum_reg + prod2_reg;

    always_comb
    begin
        sum_next = sum_reg;
        if (advance && ctl2_reg.valid)
        begin
            sum_next = ctl2_reg.row_end ? '0 : acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg      <= '0;
            ctl2_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            if (advance)
            begin
                ctl1_reg <= ctl_in;
                ctl2_reg <= ctl1_reg;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            value1_reg <= value_in;
            prod2_reg  <= prod;
        end
        if (emit)
        begin
            out_sum_reg  <= acc;
            out_idx_reg  <= ctl2_reg.row_index;
            out_last_reg <= ctl2_reg.last_row;
        end
    end

    assign res_valid     = out_valid_reg;
    assign res_sum       = out_sum_reg;
    assign res_row_index = out_idx_reg;
    assign res_last_row  = out_last_reg;

endmodule

>>> rtl/core/dmv_checker.sv
// ----------------------------------------------------------------------------
// dmv_checker
// Port-level checks on the matrix-vector multiply core, bound to the top.
// ----------------------------------------------------------------------------
`include "dense_matrix_vector_multiply_core_defines.svh"

module dmv_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [dmv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);

    // A waiting result keeps its contents until the transfer completes.
    `DMV_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

    // Input is held off only behind a result that is not being taken.
    `DMV_ASSERT_SAME(a_ready_cause, clk, rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output back-pressure")

    // The padding above row_index stays zero.
    `DMV_ASSERT_SAME(a_pad_zero, clk, rst_n, m_axis_tvalid, m_axis_tdata[47:44] == 4'b0000, "nonzero padding in result")

endmodule

bind dense_matrix_vector_multiply_core dmv_checker u_dmv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
